// ===== rtl/mouse_packet_position_tracker_defines.svh =====
// Assertion macros used by the checker module mppt_checker.
`ifndef MOUSE_PACKET_POSITION_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_POSITION_TRACKER_DEFINES_SVH

// Check a condition at every edge out of reset.
`define MPPT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as the antecedent.
`define MPPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define MPPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mppt_pkg.sv =====
package mppt_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BTN_W   = 3;

    localparam int unsigned MARGIN  = 9;

    localparam int unsigned SYNC_IDX = 3;
    localparam int unsigned XOVF_IDX = 6;
    localparam int unsigned YOVF_IDX = 7;
    localparam logic [BYTE_W-1:0] BTN_MASK = 8'h07;

    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd1024;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd768;

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic signed [BYTE_W-1:0] t_delta;
    typedef logic [BTN_W-1:0]         t_btn;

    typedef struct packed {
        logic   done;
        t_delta dx;
        t_delta dy;
        t_btn   btn;
    } t_pkt;

endpackage

// ===== rtl/mppt_if.sv =====
interface mppt_in_if;
    import mppt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mppt_out_if;
    import mppt_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    t_delta delta_x;
    t_delta delta_y;
    t_btn   buttons;
    logic   moved;

    modport source (output valid, output pos_x, output pos_y, output delta_x,
                    output delta_y, output buttons, output moved, input ready);
    modport sink (input valid, input pos_x, input pos_y, input delta_x,
                  input delta_y, input buttons, input moved, output ready);
endinterface

// ===== rtl/mouse_packet_position_tracker.sv =====
// Channel   Dir   Beat payload
// i_in      in    rx_byte
// o_out     out   pos_x, pos_y, delta_x, delta_y, buttons, moved
// i_cfg_*   in    write enable, index (0 width, 1 height), 12-bit data
//
// One byte per cycle unless a stalled o_out holds a packet's last byte; the
// third byte of a packet passes the input register, then the result register.
// Reset: synchronous active low; clears framing, cursor to 0,0, size to 1024x768.
// A stalled o_out stalls i_in only when the byte held completes a packet.
module mouse_packet_position_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mppt_in_if.sink                      i_in,
    mppt_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [mppt_pkg::COORD_W-1:0] i_cfg_data
);
    import mppt_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_coord            r_width;
    t_coord            r_height;
    t_coord            r_cur_x;
    t_coord            r_cur_y;
    logic              r_out_valid;
    t_coord            r_pos_x;
    t_coord            r_pos_y;
    t_delta            r_dx;
    t_delta            r_dy;
    t_btn              r_btn;
    logic              r_moved;

    t_pkt              pkt;
    logic              out_free;
    logic              adv;
    logic              emit;
    logic signed [8:0] dx_ext;
    logic signed [8:0] dy_neg;
    t_coord            n_cur_x;
    t_coord            n_cur_y;

    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && (!pkt.done || out_free);
    assign emit       = adv && pkt.done;
    assign i_in.ready = !r_in_valid || adv;

    assign dx_ext = {pkt.dx[BYTE_W-1], pkt.dx};
    assign dy_neg = 9'sd0 - {pkt.dy[BYTE_W-1], pkt.dy};

    mppt_assembler u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_adv   (adv),
        .o_pkt   (pkt)
    );

    mppt_clamp u_clamp_x (
        .i_pos   (r_cur_x),
        .i_delta (dx_ext),
        .i_size  (r_width),
        .o_pos   (n_cur_x)
    );

    mppt_clamp u_clamp_y (
        .i_pos   (r_cur_y),
        .i_delta (dy_neg),
        .i_size  (r_height),
        .o_pos   (n_cur_y)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pos_x <= n_cur_x;
            r_pos_y <= n_cur_y;
            r_dx    <= pkt.dx;
            r_dy    <= pkt.dy;
            r_btn   <= pkt.btn;
            r_moved <= (n_cur_x != r_cur_x) || (n_cur_y != r_cur_y);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_pos_x;
    assign o_out.pos_y   = r_pos_y;
    assign o_out.delta_x = r_dx;
    assign o_out.delta_y = r_dy;
    assign o_out.buttons = r_btn;
    assign o_out.moved   = r_moved;

endmodule

// ===== rtl/mppt_assembler.sv =====
module mppt_assembler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mppt_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_adv,
    output mppt_pkg::t_pkt              o_pkt
);
    import mppt_pkg::*;

    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_XBYTE  = 2'd1;
    localparam logic [1:0] ST_YBYTE  = 2'd2;

    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic [BYTE_W-1:0] r_hdr;
    logic [BYTE_W-1:0] n_hdr;
    logic [BYTE_W-1:0] r_xb;
    logic [BYTE_W-1:0] n_xb;
    logic              third;

    always_comb begin
        n_idx = r_idx;
        n_hdr = r_hdr;
        n_xb  = r_xb;
        third = 1'b0;
        unique case (r_idx)
            ST_HEADER: begin
                if (i_byte[SYNC_IDX]) begin
                    n_hdr = i_byte;
                    n_idx = ST_XBYTE;
                end
            end
            ST_XBYTE: begin
                n_xb  = i_byte;
                n_idx = ST_YBYTE;
            end
            default: begin
                third = 1'b1;
                n_idx = ST_HEADER;
            end
        endcase
    end

    always_comb begin
        o_pkt.done = i_valid && third;
        o_pkt.dx   = r_hdr[XOVF_IDX] ? '0 : $signed(r_xb);
        o_pkt.dy   = r_hdr[YOVF_IDX] ? '0 : $signed(i_byte);
        o_pkt.btn  = BTN_W'(r_hdr & BTN_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= ST_HEADER;
        end else if (i_adv) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hdr <= n_hdr;
            r_xb  <= n_xb;
        end
    end

endmodule

// ===== rtl/mppt_clamp.sv =====
module mppt_clamp (
    input  mppt_pkg::t_coord    i_pos,
    input  logic signed [8:0]   i_delta,
    input  mppt_pkg::t_coord    i_size,
    output mppt_pkg::t_coord    o_pos
);
    import mppt_pkg::*;

    localparam int unsigned P_W = COORD_W + 2;

    logic signed [P_W-1:0] sum;
    logic signed [P_W-1:0] size_s;
    logic signed [P_W-1:0] margin_s;
    t_coord                top;

    always_comb begin
        margin_s = $signed(P_W'(MARGIN));
        sum      = $signed({2'b00, i_pos}) + {{(P_W-9){i_delta[8]}}, i_delta};
        size_s   = $signed({2'b00, i_size});
        top      = (i_size < COORD_W'(MARGIN)) ? '0 : i_size - COORD_W'(MARGIN);
        if (sum < margin_s) begin
            o_pos = COORD_W'(MARGIN);
        end else if (sum + margin_s >= size_s) begin
            o_pos = top;
        end else begin
            o_pos = sum[COORD_W-1:0];
        end
    end

endmodule

// ===== rtl/mppt_checker.sv =====
`include "mouse_packet_position_tracker_defines.svh"

module mppt_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input mppt_pkg::t_coord       i_pos_x,
    input mppt_pkg::t_coord       i_pos_y,
    input mppt_pkg::t_delta       i_dx,
    input mppt_pkg::t_delta       i_dy,
    input mppt_pkg::t_btn         i_btn,
    input logic                   i_moved
);
    import mppt_pkg::*;

    t_coord                               r_last_x;
    t_coord                               r_last_y;
    logic                                 out_beat;
    logic                                 out_stall;
    logic                                 pos_changed;
    logic [2*COORD_W+2*BYTE_W+BTN_W:0]    out_bits;

    assign out_beat    = i_out_valid && i_out_ready;
    assign out_stall   = i_out_valid && !i_out_ready;
    assign pos_changed = (i_pos_x != r_last_x) || (i_pos_y != r_last_y);
    assign out_bits    = {i_pos_x, i_pos_y, i_dx, i_dy, i_btn, i_moved};

    // track the last delivered position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (out_beat) begin
            r_last_x <= i_pos_x;
            r_last_y <= i_pos_y;
        end
    end

    `MPPT_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(out_bits), "held beat changed")
    `MPPT_ASSERT_ALWAYS(a_stall_cause, i_in_ready || i_out_valid, "input stall without result")
    `MPPT_ASSERT_SAME(a_moved, out_beat, i_moved == pos_changed, "moved flag mismatch")
    `MPPT_ASSERT_SAME(a_reset_idle, $rose(i_rst_n), !i_out_valid, "valid right after reset")

endmodule

bind mouse_packet_position_tracker mppt_checker u_mppt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x),
    .i_pos_y     (o_out.pos_y),
    .i_dx        (o_out.delta_x),
    .i_dy        (o_out.delta_y),
    .i_btn       (o_out.buttons),
    .i_moved     (o_out.moved)
);
